// ----- hdl/ddq_pkg.sv -----
// ddq_pkg: shared types and constants for the double-ended queue.
// Request codes, item structs and the cell control bundle; no dependencies.
package ddq_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam logic [DW-1:0] NEG_ONE = '1;

  typedef enum logic [2:0] {
    REQ_QUERY      = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4
  } req_code_t;

  // Per-cycle action broadcast to every cell of a chain.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,  // shift toward higher index, new word enters cell 0
    CELL_DEL  = 2'd2,  // shift toward lower index, cell 0 drops out
    CELL_WR   = 2'd3   // write value into the cell at wr_pos only
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  wr_pos;
    logic [DW-1:0]     value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [DW-1:0] push_value;
  } ddq_in_t;

  typedef struct packed {
    logic signed [DW-1:0] pop_value;
    logic                 pop_hit;
    logic [CNT_W-1:0]     entry_count;
    logic                 is_empty;
    logic signed [DW-1:0] front_value;
    logic signed [DW-1:0] back_value;
    logic                 push_dropped;
  } ddq_out_t;

endpackage

// ----- hdl/ddq_cell.sv -----
// ddq_cell: one storage word of a shift chain.
// Depends on ddq_pkg for the control bundle.
module ddq_cell (
  input  logic                     clk,
  input  ddq_pkg::cell_ctrl_t      ctrl,
  input  logic [ddq_pkg::IDX_W-1:0] idx,
  input  logic [ddq_pkg::DW-1:0]   lower_in,
  input  logic [ddq_pkg::DW-1:0]   upper_in,
  output logic [ddq_pkg::DW-1:0]   data
);
  import ddq_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INS: data <= lower_in;
      CELL_DEL: data <= upper_in;
      CELL_WR: begin
        if (ctrl.wr_pos == idx) begin
          data <= ctrl.value;
        end
      end
      default: data <= data;
    endcase
  end

endmodule

// ----- hdl/ddq_chain.sv -----
// ddq_chain: row of DEPTH cells, word 0 at the head, neighbors linked both ways.
// Depends on ddq_pkg and ddq_cell.
module ddq_chain (
  input  logic                   clk,
  input  ddq_pkg::cell_ctrl_t    ctrl,
  output logic [ddq_pkg::DW-1:0] head
);
  import ddq_pkg::*;

  logic [DW-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] lower_in;
    logic [DW-1:0] upper_in;

    if (i == 0) begin : g_first
      assign lower_in = ctrl.value;
    end else begin : g_mid_lo
      assign lower_in = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_in = q[i];
    end else begin : g_mid_hi
      assign upper_in = q[i+1];
    end

    ddq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (IDX_W'(i)),
      .lower_in (lower_in),
      .upper_in (upper_in),
      .data     (q[i])
    );
  end

  assign head = q[0];

endmodule

// ----- hdl/double_ended_queue.sv -----
// double_ended_queue: top level of the cell-chain deque of signed words.
// Depends on ddq_pkg, ddq_chain (and through it ddq_cell).
//
//   channel   handshake          payload        direction
//   request   start / busy       req  (ddq_in_t)   in
//   response  done (strobe)      rsp  (ddq_out_t)  out
//
// One request per cycle: start is taken at any edge where busy is low, and
// busy is high only while rst is. The response strobe follows acceptance
// through the cell update, then the output register; every request gives one.
// The cell chains set the rate: they shift or write as each request is taken.
// Synchronous reset empties the queue; stored words are not cleared. The
// receiver cannot stall, so only reset holds off new requests.
//
// Two chains hold the same contents: the front chain with the front word in
// cell 0, the back chain reversed with the back word in cell 0. A push at one
// end shifts that end's chain and writes the word at position count in the
// other chain; a pop shifts only its own end's chain. Both ends are therefore
// always at a fixed cell, and no wide read mux is needed.
module double_ended_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ddq_pkg::ddq_in_t req,
  output logic             done,
  output ddq_pkg::ddq_out_t rsp
);
  import ddq_pkg::*;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cell_ctrl_t       front_ctrl;
  cell_ctrl_t       back_ctrl;
  logic [DW-1:0]    front_head;
  logic [DW-1:0]    back_head;

  // first stage: per-item flags captured when the chains update
  logic             s1_valid;
  logic [DW-1:0]    s1_pop_value;
  logic             s1_pop_hit;
  logic             s1_dropped;
  logic [DW-1:0]    pop_value_next;
  logic             pop_hit_next;
  logic             dropped_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    front_ctrl.op     = CELL_HOLD;
    front_ctrl.wr_pos = count[IDX_W-1:0];
    front_ctrl.value  = req.push_value;
    back_ctrl.op      = CELL_HOLD;
    back_ctrl.wr_pos  = count[IDX_W-1:0];
    back_ctrl.value   = req.push_value;
    count_next        = count;
    pop_value_next    = NEG_ONE;
    pop_hit_next      = 1'b0;
    dropped_next      = 1'b0;
    if (accept) begin
      case (req.req_type)
        REQ_PUSH_FRONT: begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            front_ctrl.op = CELL_INS;
            back_ctrl.op  = CELL_WR;
            count_next    = count + 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            back_ctrl.op  = CELL_INS;
            front_ctrl.op = CELL_WR;
            count_next    = count + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (!empty) begin
            front_ctrl.op  = CELL_DEL;
            pop_value_next = front_head;
            pop_hit_next   = 1'b1;
            count_next     = count - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (!empty) begin
            back_ctrl.op   = CELL_DEL;
            pop_value_next = back_head;
            pop_hit_next   = 1'b1;
            count_next     = count - 1'b1;
          end
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  ddq_chain u_front (
    .clk  (clk),
    .ctrl (front_ctrl),
    .head (front_head)
  );

  ddq_chain u_back (
    .clk  (clk),
    .ctrl (back_ctrl),
    .head (back_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      count    <= count_next;
      s1_valid <= accept;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pop_value <= pop_value_next;
    s1_pop_hit   <= pop_hit_next;
    s1_dropped   <= dropped_next;
  end

  // second stage: chains and count now show the state after the item
  always_ff @(posedge clk) begin
    rsp.pop_value    <= s1_pop_value;
    rsp.pop_hit      <= s1_pop_hit;
    rsp.entry_count  <= count;
    rsp.is_empty     <= empty;
    rsp.front_value  <= empty ? NEG_ONE : front_head;
    rsp.back_value   <= empty ? NEG_ONE : back_head;
    rsp.push_dropped <= s1_dropped;
  end

endmodule

// ----- hdl/ddq_checker.sv -----
// ddq_checker: port-level checks on the deque, bound to the top level.
// Depends on ddq_pkg and double_ended_queue.
module ddq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ddq_pkg::ddq_out_t rsp
);
  import ddq_pkg::*;

  // every accepted item is answered by a done strobe
  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item got no response");

  // no response without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("response without request");

  // empty queue reports both ends as -1 and a zero count
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.is_empty) |->
      (rsp.front_value == -1 && rsp.back_value == -1 && rsp.entry_count == '0))
    else $error("empty response inconsistent");

  // a single-entry queue has the same word at both ends
  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.entry_count == CNT_W'(1)) |->
      (rsp.front_value == rsp.back_value && !rsp.is_empty))
    else $error("single entry ends differ");

  // a pop hit never coincides with a dropped push
  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.pop_hit && rsp.push_dropped))
    else $error("pop hit and push drop together");

endmodule

bind double_ended_queue ddq_checker u_ddq_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: random and directed check of the double_ended_queue block.
// Needs ddq_pkg and the double_ended_queue RTL; predicts each response in a scoreboard class.
module testbench;
  import ddq_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request taken and no response
  localparam int SETTLE_CYCLES  = 4;     // margin after the last response before the verdict

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  ddq_in_t   req;
  logic      done;
  ddq_out_t  rsp;

  // Percentage of cycles in which the sender holds start low before an item.
  int        idle_pct;
  int        stall_cycles;

  // Scoreboard: keeps a shadow copy of the ring (head, fill, words), turns every
  // accepted request into the response it must produce, and checks responses
  // against those in arrival order.
  class deque_tracker;
    logic [DW-1:0]     shadow_words [DEPTH];
    int unsigned       shadow_head;
    int unsigned       shadow_fill;
    ddq_out_t          expected_rsps [$];
    int                errors;
    int                rsp_seen;

    function new();
      shadow_head = 0;
      shadow_fill = 0;
      errors      = 0;
      rsp_seen    = 0;
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH response %0d: %s", rsp_seen, msg);
      errors++;
    endtask

    // Apply one request to the shadow queue and store the response it implies.
    task note_request(ddq_in_t item);
      ddq_out_t     r;
      int unsigned  back_slot;
      r              = '0;
      r.pop_value    = NEG_ONE;
      case (item.req_type)
        REQ_PUSH_FRONT: begin
          if (shadow_fill == DEPTH) r.push_dropped = 1'b1;
          else begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_words[shadow_head] = item.push_value;
            shadow_fill++;
          end
        end
        REQ_PUSH_BACK: begin
          if (shadow_fill == DEPTH) r.push_dropped = 1'b1;
          else begin
            shadow_words[(shadow_head + shadow_fill) % DEPTH] = item.push_value;
            shadow_fill++;
          end
        end
        REQ_POP_FRONT: begin
          if (shadow_fill != 0) begin
            r.pop_value = shadow_words[shadow_head];
            r.pop_hit   = 1'b1;
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_fill--;
          end
        end
        REQ_POP_BACK: begin
          if (shadow_fill != 0) begin
            r.pop_value = shadow_words[(shadow_head + shadow_fill - 1) % DEPTH];
            r.pop_hit   = 1'b1;
            shadow_fill--;
          end
        end
        default: ;  // query and the unused codes leave the queue alone
      endcase
      r.entry_count = shadow_fill[CNT_W-1:0];
      r.is_empty    = (shadow_fill == 0);
      if (shadow_fill == 0) begin
        r.front_value = NEG_ONE;
        r.back_value  = NEG_ONE;
      end else begin
        back_slot     = (shadow_head + shadow_fill - 1) % DEPTH;
        r.front_value = shadow_words[shadow_head];
        r.back_value  = shadow_words[back_slot];
      end
      expected_rsps = {expected_rsps, r};
    endtask

    task compare_field(string field, logic [DW-1:0] got, logic [DW-1:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", field, got, want));
    endtask

    task check_response(ddq_out_t got);
      ddq_out_t want;
      if (expected_rsps.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        want = expected_rsps[0];
        expected_rsps.delete(0);
        compare_field("pop_value",    got.pop_value,    want.pop_value);
        compare_field("pop_hit",      got.pop_hit,      want.pop_hit);
        compare_field("entry_count",  got.entry_count,  want.entry_count);
        compare_field("is_empty",     got.is_empty,     want.is_empty);
        compare_field("front_value",  got.front_value,  want.front_value);
        compare_field("back_value",   got.back_value,   want.back_value);
        compare_field("push_dropped", got.push_dropped, want.push_dropped);
      end
      rsp_seen++;
    endtask
  endclass

  deque_tracker tracker;

  double_ended_queue dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Responses are a one-cycle strobe; the receiver has no way to stall, so
  // every strobe seen at a rising edge is taken and checked.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(rsp);
  end

  // Watchdog: any cycle that moves a request or a response restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One request: optional idle cycles at the current rate, then hold start
  // until an edge with busy low takes it. Start stays high into the next
  // item when no idle cycle is drawn, so back-to-back traffic runs at full rate.
  task send_request(logic [2:0] code, logic [DW-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    req.req_type   <= code;
    req.push_value <= value;
    do @(posedge clk); while (busy);
    tracker.note_request(req);
  endtask

  // Sender holds off until every outstanding response has come back.
  task wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Push words: mostly random, now and then the signed extremes, zero and -1.
  function logic [DW-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return NEG_ONE;
      default: return $urandom;
    endcase
  endfunction

  function logic [2:0] pick_code(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct)
      return $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    if (roll < push_pct + pop_pct)
      return $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
    // Query share: plain query or one of the unused codes 5..7.
    if ($urandom_range(3) == 0) return REQ_QUERY;
    return 3'($urandom_range(7, 5));
  endfunction

  // Random burst with a given mix; the idle rate steps through no idling,
  // 45 percent and 17 percent every hundred items.
  task run_random(int count, int push_pct, int pop_pct);
    for (int i = 0; i < count; i++) begin
      case ((i / 100) % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 45;
        default: idle_pct = 17;
      endcase
      send_request(pick_code(push_pct, pop_pct), pick_word());
    end
  endtask

  initial begin
    tracker        = new();
    idle_pct       = 0;
    stall_cycles   = 0;
    rst            = 1'b1;
    start          = 1'b0;
    req            = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: queries and pops on an empty queue, signed extremes at both
    // ends, unused codes, draining to empty and popping past it.
    send_request(REQ_QUERY,      32'h1234_5678);
    send_request(REQ_POP_FRONT,  32'h0);
    send_request(REQ_POP_BACK,   32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK,  32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_QUERY,      32'h0);
    send_request(REQ_PUSH_BACK,  NEG_ONE);
    send_request(REQ_PUSH_FRONT, 32'h0000_0000);
    send_request(3'd5,           32'hDEAD_BEEF);
    send_request(3'd6,           32'h5555_5555);
    send_request(3'd7,           32'hAAAA_AAAA);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_POP_FRONT,  32'h0);
    send_request(REQ_POP_FRONT,  32'h0);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_POP_FRONT,  32'h0);   // empty again
    send_request(REQ_PUSH_FRONT, 32'h5555_5555);
    send_request(REQ_PUSH_BACK,  32'hAAAA_AAAA);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_POP_BACK,   32'h0);   // pop past empty from the back
    wait_for_drain();

    // Mixed traffic around empty, then a push-heavy run that fills the ring
    // and keeps pushing into it while full, then a pop-heavy run back down.
    run_random(200, 40, 40);
    run_random(1150, 96, 3);
    wait_for_drain();
    run_random(700, 3, 96);
    run_random(200, 40, 40);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
